### rtl/core/tic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tic_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;
  localparam logic        MODE_RESET     = 1'b1;

endpackage

`default_nettype wire

### rtl/core/tic_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module tic_div_pipe #(
  parameter int LANES = 1,
  parameter int DW    = 8,
  parameter int QW    = 8,
  parameter int TAGW  = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  logic [LANES-1:0][DW-1:0]     num_hi,
  input  logic [LANES-1:0][QW-1:0]     num_lo,
  input  logic [LANES-1:0][DW-1:0]     den,
  input  logic [TAGW-1:0]              in_tag,
  output logic                         out_v,
  output logic [LANES-1:0][QW-1:0]     quo,
  output logic [TAGW-1:0]              out_tag
);

  // restoring division, one quotient bit per stage; num_hi must be below den
  logic [DW-1:0]   rem_r [QW][LANES];
  logic [DW-1:0]   den_r [QW][LANES];
  logic [QW-1:0]   sh_r  [QW][LANES];
  logic            v_r   [QW];
  logic [TAGW-1:0] tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic            v_s;
    logic [TAGW-1:0] tag_s;

    if (k == 0) begin : g_first
      assign v_s   = in_v;
      assign tag_s = in_tag;
    end else begin : g_next
      assign v_s   = v_r[k-1];
      assign tag_s = tag_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tag_s;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW-1:0] rem_s;
      logic [DW-1:0] den_s;
      logic [QW-1:0] sh_s;
      logic [DW:0]   rem2;
      logic [DW:0]   diff;
      logic          ge;

      if (k == 0) begin : g_first
        assign rem_s = num_hi[l];
        assign den_s = den[l];
        assign sh_s  = num_lo[l];
      end else begin : g_next
        assign rem_s = rem_r[k-1][l];
        assign den_s = den_r[k-1][l];
        assign sh_s  = sh_r[k-1][l];
      end

      assign rem2 = {rem_s, sh_s[QW-1]};
      assign diff = rem2 - {1'b0, den_s};
      assign ge   = (rem2 >= {1'b0, den_s});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= ge ? diff[DW-1:0] : rem2[DW-1:0];
          den_r[k][l] <= den_s;
          sh_r[k][l]  <= {sh_s[QW-2:0], ge};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = sh_r[QW-1][l];
    end
  end

  assign out_v   = v_r[QW-1];
  assign out_tag = tag_r[QW-1];

endmodule

`default_nettype wire

### rtl/core/tic_sqrt_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module tic_sqrt_pipe #(
  parameter int LANES = 1,
  parameter int W     = 8,
  parameter int TAGW  = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [LANES-1:0][W-1:0]    rad,
  input  logic [TAGW-1:0]            in_tag,
  output logic                       out_v,
  output logic [LANES-1:0][W/2-1:0]  root,
  output logic [TAGW-1:0]            out_tag
);

  localparam int R = W / 2;

  // floor square root, one root bit per stage
  logic [R+1:0]    rem_r  [R][LANES];
  logic [R-1:0]    root_r [R][LANES];
  logic [W-1:0]    sh_r   [R][LANES];
  logic            v_r    [R];
  logic [TAGW-1:0] tag_r  [R];

  for (genvar k = 0; k < R; k++) begin : g_stage
    logic            v_s;
    logic [TAGW-1:0] tag_s;

    if (k == 0) begin : g_first
      assign v_s   = in_v;
      assign tag_s = in_tag;
    end else begin : g_next
      assign v_s   = v_r[k-1];
      assign tag_s = tag_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tag_s;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [R+1:0] rem_s;
      logic [R-1:0] root_s;
      logic [W-1:0] sh_s;
      logic [R+1:0] rem2;
      logic [R+1:0] trial;
      logic         ge;

      if (k == 0) begin : g_first
        assign rem_s  = '0;
        assign root_s = '0;
        assign sh_s   = rad[l];
      end else begin : g_next
        assign rem_s  = rem_r[k-1][l];
        assign root_s = root_r[k-1][l];
        assign sh_s   = sh_r[k-1][l];
      end

      assign rem2  = {rem_s[R-1:0], sh_s[W-1:W-2]};
      assign trial = {root_s, 2'b01};
      assign ge    = (rem2 >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l]  <= ge ? (rem2 - trial) : rem2;
          root_r[k][l] <= {root_s[R-2:0], ge};
          sh_r[k][l]   <= {sh_s[W-3:0], 2'b00};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root[l] = root_r[R-1][l];
    end
  end

  assign out_v   = v_r[R-1];
  assign out_tag = tag_r[R-1];

endmodule

`default_nettype wire

### rtl/core/triangle_incircle.sv
`timescale 1ns / 1ps
`default_nettype none

// One triangle per cycle while the skid register is empty; set by the bit-per-stage square root and divider pipes.
// A stalled output parks one result in a skid register; in_tready drops while it is full.
// Reset (rst_n low, synchronous): pipeline empty, no output, centre_depth_mode = 1.
module triangle_incircle #(
  parameter int COORD_BITS = tic_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // x0, y0, z0, x1, y1, z1, x2, y2, z2, zero pad
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // centre_x, centre_y, centre_z, inradius, zero pad
  output logic [((4*COORD_BITS+6)/8)*8-1:0]      out_tdata,
  // degenerate
  output logic [0:0]                             out_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [0:0]                             cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int L     = C + 1;
  localparam int SQW   = 2 * C + 2;
  localparam int PW    = C + 3;
  localparam int TW    = C + 2;
  localparam int PRW   = 2 * C + 2;
  localparam int WSW   = 2 * C + 4;
  localparam int MW    = 2 * C + 3;
  localparam int QR    = 2 * C + 2;
  localparam int OUT_W = ((4 * C + 6) / 8) * 8;
  localparam logic [PW-1:0] MEAN_DIV = PW'(3);

  logic en;
  logic mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tic_pkg::MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data[0];
    end
  end

  // stage 1: coordinate differences per side
  logic [2:0][2:0][C-1:0] vtx_in;
  logic [2:0][2:0][C:0]   dm_nxt;
  logic [2:0][2:0][C:0]   dm1_r;
  logic [2:0][2:0][C-1:0] vtx1_r;
  logic                   mode1_r;
  logic                   v1_r;

  assign vtx_in = in_tdata[9*C-1:0];

  always_comb begin
    logic [C:0] d;
    int         ip;
    int         iq;
    d = '0;
    for (int s = 0; s < 3; s++) begin
      ip = (s == 2) ? 0 : s + 1;
      iq = (s == 0) ? 2 : s - 1;
      for (int k = 0; k < 3; k++) begin
        d = {vtx_in[iq][k][C-1], vtx_in[iq][k]} - {vtx_in[ip][k][C-1], vtx_in[ip][k]};
        dm_nxt[s][k] = d[C] ? (~d + 1'b1) : d;
      end
    end
  end

  // stage 2/3: squares, sums
  logic [2:0][2:0][SQW-1:0] sq2_r;
  logic [2:0][2:0][C-1:0]   vtx2_r;
  logic                     mode2_r;
  logic                     v2_r;
  logic [2:0][SQW-1:0]      ss3_r;
  logic [2:0][2:0][C-1:0]   vtx3_r;
  logic                     mode3_r;
  logic                     v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dm1_r   <= dm_nxt;
      vtx1_r  <= vtx_in;
      mode1_r <= mode_r;
      for (int s = 0; s < 3; s++) begin
        for (int k = 0; k < 3; k++) begin
          sq2_r[s][k] <= SQW'(dm1_r[s][k]) * SQW'(dm1_r[s][k]);
        end
        ss3_r[s] <= sq2_r[s][0] + sq2_r[s][1] + sq2_r[s][2];
      end
      vtx2_r  <= vtx1_r;
      mode2_r <= mode1_r;
      vtx3_r  <= vtx2_r;
      mode3_r <= mode2_r;
    end
  end

  // side lengths
  logic                 sd_v;
  logic [2:0][L-1:0]    side;
  logic [9*C:0]         sd_tag;

  tic_sqrt_pipe #(
    .LANES (3),
    .W     (SQW),
    .TAGW  (9 * C + 1)
  ) u_side_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v3_r),
    .rad     (ss3_r),
    .in_tag  ({mode3_r, vtx3_r}),
    .out_v   (sd_v),
    .root    (side),
    .out_tag (sd_tag)
  );

  // stage 4: perimeter, Heron terms, weight products
  logic [2:0][2:0][C-1:0]   vtx_s;
  logic [2:0][2:0][PRW-1:0] prod_nxt;
  logic [2:0][TW-1:0]       t_nxt;
  logic [C+1:0]             zs_nxt;
  logic                     ok_nxt;

  assign vtx_s = sd_tag[9*C-1:0];

  always_comb begin
    logic [L:0] ae;
    logic [L:0] be;
    logic [L:0] ce;
    ae = {1'b0, side[0]};
    be = {1'b0, side[1]};
    ce = {1'b0, side[2]};
    ok_nxt   = (ae <= be + ce) && (be <= ae + ce) && (ce <= ae + be);
    t_nxt[0] = be + ce - ae;
    t_nxt[1] = ae + ce - be;
    t_nxt[2] = ae + be - ce;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        prod_nxt[k][i] = $signed({1'b0, side[i]}) * $signed(vtx_s[i][k]);
      end
    end
    zs_nxt = {{2{vtx_s[0][2][C-1]}}, vtx_s[0][2]} + {{2{vtx_s[1][2][C-1]}}, vtx_s[1][2]}
           + {{2{vtx_s[2][2][C-1]}}, vtx_s[2][2]};
  end

  logic [2:0][2:0][PRW-1:0] prod4_r;
  logic [PW-1:0]            p4_r;
  logic [2:0][TW-1:0]       t4_r;
  logic                     ok4_r;
  logic [C+1:0]             zs4_r;
  logic                     mode4_r;
  logic                     v4_r;

  // stage 5: weighted sums, t1*t2
  logic [2:0][WSW-1:0]      ws5_r;
  logic [2*TW-1:0]          p12_5_r;
  logic [TW-1:0]            t3_5_r;
  logic [PW-1:0]            p5_r;
  logic                     ok5_r;
  logic [C+1:0]             zs5_r;
  logic                     mode5_r;
  logic                     v5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod4_r <= prod_nxt;
      p4_r    <= PW'(side[0]) + PW'(side[1]) + PW'(side[2]);
      t4_r    <= t_nxt;
      ok4_r   <= ok_nxt;
      zs4_r   <= zs_nxt;
      mode4_r <= sd_tag[9*C];
      for (int k = 0; k < 3; k++) begin
        ws5_r[k] <= {{2{prod4_r[k][0][PRW-1]}}, prod4_r[k][0]}
                  + {{2{prod4_r[k][1][PRW-1]}}, prod4_r[k][1]}
                  + {{2{prod4_r[k][2][PRW-1]}}, prod4_r[k][2]};
      end
      p12_5_r <= (2*TW)'(t4_r[0]) * (2*TW)'(t4_r[1]);
      t3_5_r  <= t4_r[2];
      p5_r    <= p4_r;
      ok5_r   <= ok4_r;
      zs5_r   <= zs4_r;
      mode5_r <= mode4_r;
    end
  end

  // stage 6: divider operands, split t1*t2*t3
  logic [2:0][MW-1:0]   cn_nxt;
  logic [2:0]           neg_nxt;
  logic [2:0][PW-1:0]   den_nxt;

  always_comb begin
    logic [WSW-1:0] m;
    logic [C+1:0]   mz;
    m  = '0;
    mz = '0;
    for (int l = 0; l < 3; l++) begin
      if (l == 2 && !mode5_r) begin
        neg_nxt[l] = zs5_r[C+1];
        mz         = zs5_r[C+1] ? (~zs5_r + 1'b1) : zs5_r;
        cn_nxt[l]  = {{(MW-C-2){1'b0}}, mz};
        den_nxt[l] = MEAN_DIV;
      end else begin
        neg_nxt[l] = ws5_r[l][WSW-1];
        m          = ws5_r[l][WSW-1] ? (~ws5_r[l] + 1'b1) : ws5_r[l];
        cn_nxt[l]  = m[MW-1:0];
        den_nxt[l] = p5_r;
      end
    end
  end

  logic [2:0][MW-1:0]   cn6_r;
  logic [2:0]           neg6_r;
  logic [2:0][PW-1:0]   den6_r;
  logic [PW-1:0]        p6_r;
  logic [2*TW-1:0]      mh6_r;
  logic [2*TW-1:0]      ml6_r;
  logic                 ok6_r;
  logic                 deg6_r;
  logic                 v6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cn6_r  <= cn_nxt;
      neg6_r <= neg_nxt;
      den6_r <= den_nxt;
      p6_r   <= p5_r;
      mh6_r  <= (2*TW)'(p12_5_r[2*TW-1:TW]) * (2*TW)'(t3_5_r);
      ml6_r  <= (2*TW)'(p12_5_r[TW-1:0]) * (2*TW)'(t3_5_r);
      ok6_r  <= ok5_r;
      deg6_r <= (p5_r == '0);
    end
  end

  // centre division
  localparam int CTW = 4 * TW + PW + 5;

  logic [2:0][PW-1:0]   cd_hi;
  logic [2:0][C-1:0]    cd_lo;
  logic                 cd_v;
  logic [2:0][C-1:0]    cd_q;
  logic [CTW-1:0]       cd_tag;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cd_hi[l] = cn6_r[l][MW-1:C];
      cd_lo[l] = cn6_r[l][C-1:0];
    end
  end

  tic_div_pipe #(
    .LANES (3),
    .DW    (PW),
    .QW    (C),
    .TAGW  (CTW)
  ) u_centre_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v6_r),
    .num_hi  (cd_hi),
    .num_lo  (cd_lo),
    .den     (den6_r),
    .in_tag  ({mh6_r, ml6_r, p6_r, ok6_r, deg6_r, neg6_r}),
    .out_v   (cd_v),
    .quo     (cd_q),
    .out_tag (cd_tag)
  );

  // stage 7: centre saturation, full Heron product
  logic [2:0][C-1:0]    cen_nxt;
  logic [2:0]           cneg;
  logic [2*TW-1:0]      cmh;
  logic [2*TW-1:0]      cml;

  assign cneg = cd_tag[2:0];
  assign cml  = cd_tag[PW+5 +: 2*TW];
  assign cmh  = cd_tag[PW+5+2*TW +: 2*TW];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (cneg[l]) begin
        if (cd_q[l][C-1] && (|cd_q[l][C-2:0])) begin
          cen_nxt[l] = {1'b1, {(C-1){1'b0}}};
        end else begin
          cen_nxt[l] = ~cd_q[l] + 1'b1;
        end
      end else begin
        cen_nxt[l] = cd_q[l][C-1] ? {1'b0, {(C-1){1'b1}}} : cd_q[l];
      end
    end
  end

  logic [2:0][C-1:0]    cen7_r;
  logic [3*TW-1:0]      prod7_r;
  logic [PW-1:0]        p7_r;
  logic                 ok7_r;
  logic                 deg7_r;
  logic                 v7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cen7_r  <= cen_nxt;
      prod7_r <= {cmh, {TW{1'b0}}} + {{TW{1'b0}}, cml};
      p7_r    <= cd_tag[PW+4:5];
      ok7_r   <= cd_tag[4];
      deg7_r  <= cd_tag[3];
    end
  end

  // radius: floor(t1*t2*t3 / p), then square root
  logic                 rd_v;
  logic [0:0][QR-1:0]   rd_q;
  logic [3*C+1:0]       rd_tag;
  logic                 rt_v;
  logic [0:0][C:0]      rt_root;
  logic [3*C+1:0]       rt_tag;

  tic_div_pipe #(
    .LANES (1),
    .DW    (PW),
    .QW    (QR),
    .TAGW  (3 * C + 2)
  ) u_heron_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v7_r),
    .num_hi  (prod7_r[QR+PW-1:QR]),
    .num_lo  (prod7_r[QR-1:0]),
    .den     (p7_r),
    .in_tag  ({cen7_r, ok7_r, deg7_r}),
    .out_v   (rd_v),
    .quo     (rd_q),
    .out_tag (rd_tag)
  );

  tic_sqrt_pipe #(
    .LANES (1),
    .W     (QR),
    .TAGW  (3 * C + 2)
  ) u_radius_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (rd_v),
    .rad     (rd_q),
    .in_tag  (rd_tag),
    .out_v   (rt_v),
    .root    (rt_root),
    .out_tag (rt_tag)
  );

  // stage 8: radius halving, saturation, degenerate masking
  logic [OUT_W-1:0]     fin_nxt;
  logic [C-2:0]         rad;

  always_comb begin
    if (!rt_tag[1]) begin
      rad = '0;
    end else if (rt_root[0][C]) begin
      rad = {(C-1){1'b1}};
    end else begin
      rad = rt_root[0][C-1:1];
    end
    fin_nxt = '0;
    if (!rt_tag[0]) begin
      fin_nxt[3*C-1:0]   = rt_tag[3*C+1:2];
      fin_nxt[4*C-2:3*C] = rad;
    end
  end

  logic [OUT_W-1:0]     fin_r;
  logic                 fdeg_r;
  logic                 fv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r  <= fin_nxt;
      fdeg_r <= rt_tag[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      fv_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= sd_v;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= cd_v;
      fv_r <= rt_v;
    end
  end

  // output register with one skid entry
  logic                 out_v_r;
  logic [OUT_W-1:0]     out_data_r;
  logic                 out_user_r;
  logic                 skid_v_r;
  logic [OUT_W-1:0]     skid_data_r;
  logic                 skid_user_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= fv_r;
      end
    end else if (fv_r && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end else begin
        out_data_r <= fin_r;
        out_user_r <= fdeg_r;
      end
    end else if (en) begin
      skid_data_r <= fin_r;
      skid_user_r <= fdeg_r;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

endmodule

`default_nettype wire

### rtl/core/tic_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tic_sva #(
  parameter int COORD_BITS = tic_pkg::COORD_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((4*COORD_BITS+6)/8)*8-1:0]   out_tdata,
  input logic [0:0]                          out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("degenerate result carries nonzero fields");

  a_skid_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input blocked with no result pending");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

endmodule

bind triangle_incircle tic_sva #(
  .COORD_BITS (COORD_BITS)
) u_tic_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

### dv/tic_checker.sv
`timescale 1ns / 1ps

module tic_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [287:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [0:0]   cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] radius;
    logic        degen;
  } circle_t;

  localparam logic [127:0] POS_LIM = 128'h7fff_ffff;
  localparam logic [127:0] NEG_LIM = 128'h8000_0000;

  logic    depth_mode;
  circle_t circles_due[$];

  function automatic logic [63:0] isqrt(input logic [127:0] n);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] edge_len(input logic signed [63:0] p[3],
                                           input logic signed [63:0] q[3]);
    logic [127:0] sum;
    logic [63:0]  d;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      d = abs64(q[k] - p[k]);
      sum += {64'd0, d} * {64'd0, d};
    end
    return isqrt(sum);
  endfunction

  function automatic logic [31:0] blend(input logic [63:0] w[3],
                                        input logic signed [63:0] v[3],
                                        input logic [63:0] per);
    logic [127:0] pos, neg, m, q;
    logic         is_neg;
    pos = '0;
    neg = '0;
    for (int k = 0; k < 3; k++) begin
      if (v[k] < 0) neg += {64'd0, w[k]} * {64'd0, abs64(v[k])};
      else          pos += {64'd0, w[k]} * {64'd0, abs64(v[k])};
    end
    is_neg = pos < neg;
    m = is_neg ? neg - pos : pos - neg;
    q = m / {64'd0, per};
    if (is_neg && q > NEG_LIM) q = NEG_LIM;
    if (!is_neg && q > POS_LIM) q = POS_LIM;
    return is_neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic circle_t incircle(input logic [287:0] d, input logic mode);
    logic signed [63:0] v[3][3];
    logic signed [63:0] col[3];
    logic signed [63:0] zsum;
    logic [63:0]        w[3];
    logic [63:0]        a, b, c, per, t1, t2, t3, rad;
    logic [127:0]       n;
    circle_t            r;
    for (int i = 0; i < 9; i++) v[i / 3][i % 3] = $signed(d[32 * i +: 32]);
    a = edge_len(v[1], v[2]);
    b = edge_len(v[2], v[0]);
    c = edge_len(v[0], v[1]);
    per = a + b + c;
    r = '0;
    if (per == 0) begin
      r.degen = 1'b1;
      return r;
    end
    w[0] = a;
    w[1] = b;
    w[2] = c;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) col[i] = v[i][k];
      case (k)
        0: r.cx = blend(w, col, per);
        1: r.cy = blend(w, col, per);
        default: r.cz = blend(w, col, per);
      endcase
    end
    if (!mode) begin
      zsum = (v[0][2] + v[1][2] + v[2][2]) / 3;
      r.cz = zsum[31:0];
    end
    rad = '0;
    if (a <= b + c && b <= a + c && c <= a + b) begin
      t1 = b + c - a;
      t2 = a + c - b;
      t3 = a + b - c;
      n = ({64'd0, t1} * {64'd0, t2} * {64'd0, t3}) / {64'd0, per};
      rad = isqrt(n) >> 1;
      if (rad > 64'h7fff_ffff) rad = 64'h7fff_ffff;
    end
    r.radius = rad[30:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("%0t mismatch %s: expected %h, got %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    circle_t exp_c;
    if (!rst_n) begin
      depth_mode <= tic_pkg::MODE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) depth_mode <= cfg_data[0];
      if (in_tvalid && in_tready)
        circles_due.insert(circles_due.size(), incircle(in_tdata, depth_mode));
      if (out_tvalid && out_tready) begin
        if (circles_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t unexpected result transfer", $realtime);
        end else begin
          exp_c = circles_due.pop_front();
          check_field("centre_x", exp_c.cx, out_tdata[31:0]);
          check_field("centre_y", exp_c.cy, out_tdata[63:32]);
          check_field("centre_z", exp_c.cz, out_tdata[95:64]);
          check_field("inradius", {1'b0, exp_c.radius}, {1'b0, out_tdata[126:96]});
          check_field("degenerate", {31'd0, exp_c.degen}, {31'd0, out_tuser[0]});
        end
      end
    end
  end

  initial errors = 0;
  assign pending = circles_due.size();

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY   = 173;
  localparam int MAX_CYCLE = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_data = '0;

  int errors, pending, cycles;
  bit calm;
  bit stall_req;
  int stall_cnt;

  always #2 clk = ~clk;

  triangle_incircle dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  tic_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt--;
      out_tready <= 1'b0;
    end else if (stall_req) begin
      stall_req = 1'b0;
      stall_cnt = 3 * LATENCY;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || $urandom_range(99) >= 27;
    end
  end

  function automatic logic [287:0] pack_tri(input logic signed [31:0] c[9]);
    logic [287:0] d;
    for (int i = 0; i < 9; i++) d[32 * i +: 32] = c[i];
    return d;
  endfunction

  function automatic logic [287:0] random_tri();
    logic signed [31:0] c[9];
    logic signed [31:0] dir[3];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      case (kind)
        0, 1, 2: c[i] = $urandom;
        3, 4, 5: c[i] = $signed($urandom_range(2097151)) - 1048576;
        6:       c[i] = (i < 3) ? $urandom : c[i - 3] + $signed($urandom_range(7)) - 3;
        7:       c[i] = (i < 3) ? $urandom : c[i - 3];
        default: c[i] = $urandom;
      endcase
    end
    if (kind >= 8) begin
      // collinear points with small integer steps
      for (int k = 0; k < 3; k++) dir[k] = $signed($urandom_range(6)) - 3;
      for (int k = 0; k < 3; k++) begin
        c[3 + k] = c[k] + dir[k];
        c[6 + k] = c[k] + dir[k] * $signed($urandom_range(4) + 1);
      end
    end
    return pack_tri(c);
  endfunction

  task automatic send_tri(input logic [287:0] d);
    while (!calm && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || stall_cnt != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed(input logic signed [31:0] c0, c1, c2, c3, c4, c5,
                          c6, c7, c8);
    logic signed [31:0] c[9];
    c = '{c0, c1, c2, c3, c4, c5, c6, c7, c8};
    send_tri(pack_tri(c));
  endtask

  localparam logic signed [31:0] MX = 32'sh7fff_ffff;
  localparam logic signed [31:0] MN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  task automatic directed_set();
    directed(0, 0, 0, 0, 0, 0, 0, 0, 0);
    directed(MX, MX, MX, MX, MX, MX, MX, MX, MX);
    directed(MN, MN, MN, MN, MN, MN, MN, MN, MN);
    directed(MN, MN, MN, MX, MX, MX, MN, MX, MN);
    directed(MX, MN, MX, MN, MX, MN, MX, MX, MN);
    directed(MN, MN, MX, MN, MN, MX, MX, MX, MN);
    directed(0, 0, 0, 3 * ONE, 0, 0, 0, 4 * ONE, 0);
    directed(-ONE, -ONE, -ONE, -4 * ONE, -ONE, -ONE, -ONE, -5 * ONE, -7 * ONE);
    directed(0, 0, 0, 1, 1, 0, 3, 3, 0);
    directed(0, 0, 0, 1, 0, 0, 2, 0, 0);
    directed(0, 0, 0, 1, 0, 0, 0, 1, 0);
    directed(5, 5, 5, 5, 5, 5, 5, 5, 6);
    directed(MX, 0, MN, MN, 0, MX, 0, MX, 0);
    directed(-7, 9, -11, 100 * ONE, -3 * ONE, 2 * ONE, -ONE, 50 * ONE, -9 * ONE);
    directed(32'sh5555_5555, 32'shaaaa_aaaa, 0, 32'shaaaa_aaaa, 32'sh5555_5555, -1,
             -1, -1, 32'sh1234_5678);
  endtask

  initial begin
    calm = 1'b0;
    stall_req = 1'b0;
    stall_cnt = 0;
    cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_set();
    write_mode(1'b0);
    directed_set();
    write_mode(1'b1);

    for (int i = 0; i < 200; i++) send_tri(random_tri());

    // back-to-back stretch with a long hold-off on results
    calm = 1'b1;
    stall_req = 1'b1;
    for (int i = 0; i < 250; i++) send_tri(random_tri());
    calm = 1'b0;

    write_mode(1'b0);
    for (int i = 0; i < 100; i++) send_tri(random_tri());
    drain();
    for (int i = 0; i < 70; i++) send_tri(random_tri());
    write_mode(1'b1);
    for (int i = 0; i < 30; i++) send_tri(random_tri());

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
